// ===== src/tcr_pkg.sv =====
// Shared types, constants and helpers for the textured column renderer.
// Used by every module of the block; depends on nothing else.
package tcr_pkg;

    // Texture store geometry; the depth is a power of two so that the
    // address wraps by masking.
    localparam int TEXTURE_DEPTH = 4096;
    localparam int TEX_AW        = $clog2(TEXTURE_DEPTH);
    // Texel row times texture width plus column, before the wrap.
    localparam int TEX_IDX_W     = TEX_AW + 8;

    // Fixed-point format of the texture position and step.
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 40;
    localparam int STEP_W    = 32;

    // Step divider: texture height (7 bits) shifted by the fraction width.
    localparam int DIV_W     = 7 + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam logic [STEP_W-1:0] STEP_SAT = 32'h7FFF_FFFF;

    // Command queue between the front and back ends (power of two depth).
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING_COLOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_COLOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_HEIGHT = 3'd5;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_PIXEL = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_START,
        CMD_PIXEL
    } t_cmd_kind;

    typedef enum logic [1:0] {
        RG_CEILING = 2'd0,
        RG_WALL    = 2'd1,
        RG_FLOOR   = 2'd2
    } t_region;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_DIV,
        BK_MUL
    } t_back_state;

    typedef struct packed {
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [23:0] ceiling_color;
        logic [23:0] floor_color;
        logic [6:0]  texture_width;
        logic [6:0]  texture_height;
    } t_cfg;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [11:0]        column_x;
        logic [11:0]        span_start;
        logic [12:0]        span_end;
        logic [15:0]        wall_rows;
        logic [15:0]        hit_fraction;
        logic [TEX_AW-1:0]  texel_index;
        logic [31:0]        texel_value;
    } t_cmd;

    function automatic logic [12:0] floor_minus_one(input logic [12:0] v);
        return (v != 13'd0) ? (v - 13'd1) : 13'd0;
    endfunction

endpackage

// ===== src/tcr_front.sv =====
// Front end: accepts input items, classifies them by opcode and queues them.
// Depends on tcr_pkg for the command type and queue geometry.
module tcr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [11:0]        i_column_x,
    input  logic [11:0]        i_span_start,
    input  logic [12:0]        i_span_end,
    input  logic [15:0]        i_wall_rows,
    input  logic [15:0]        i_hit_fraction,
    input  logic [11:0]        i_texel_index,
    input  logic [31:0]        i_texel_value,
    input  logic               i_pop,
    output logic               o_head_valid,
    output tcr_pkg::t_cmd      o_head
);

    tcr_pkg::t_cmd                  r_queue [tcr_pkg::QUEUE_DEPTH];
    logic [tcr_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [tcr_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [tcr_pkg::QCNT_W-1:0]     r_count;
    logic [tcr_pkg::QCNT_W-1:0]     n_count;

    tcr_pkg::t_cmd  cmd;
    logic           known;
    logic           push;
    logic [31:0]    index_ext;

    assign o_in_stall   = (r_count == tcr_pkg::QCNT_W'(tcr_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_queue[r_rd_ptr];
    assign index_ext    = 32'(i_texel_index);

    always_comb begin
        known            = 1'b1;
        cmd.kind         = tcr_pkg::CMD_PIXEL;
        cmd.column_x     = i_column_x;
        cmd.span_start   = i_span_start;
        cmd.span_end     = i_span_end;
        cmd.wall_rows    = i_wall_rows;
        cmd.hit_fraction = i_hit_fraction;
        cmd.texel_index  = index_ext[tcr_pkg::TEX_AW-1:0];
        cmd.texel_value  = i_texel_value;
        case (i_opcode)
            tcr_pkg::OP_LOAD:  cmd.kind = tcr_pkg::CMD_LOAD;
            tcr_pkg::OP_START: cmd.kind = tcr_pkg::CMD_START;
            tcr_pkg::OP_PIXEL: cmd.kind = tcr_pkg::CMD_PIXEL;
            // The unused opcode is accepted and dropped here.
            default:           known = 1'b0;
        endcase
    end

    assign push = i_in_valid && !o_in_stall && known;

    always_comb begin
        n_count = r_count;
        case ({push, i_pop})
            2'b10:   n_count = r_count + tcr_pkg::QCNT_W'(1);
            2'b01:   n_count = r_count - tcr_pkg::QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + tcr_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + tcr_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd;
        end
    end

endmodule

// ===== src/tcr_div.sv =====
// Bit-serial restoring divider for the per-column texture step.
// Produces one quotient bit per cycle; depends on tcr_pkg for widths.
module tcr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tcr_pkg::DIV_W-1:0]   i_dividend,
    input  logic [15:0]                 i_divisor,
    output logic                        o_done,
    output logic [tcr_pkg::DIV_W-1:0]   o_quotient
);

    logic                              r_busy;
    logic                              r_done;
    logic [tcr_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [15:0]                       r_rem;
    logic [15:0]                       r_divisor;
    logic [tcr_pkg::DIV_W-1:0]         r_quo;

    logic [16:0] trial;
    logic [16:0] diff;
    logic        fits;
    logic [15:0] n_rem;

    // The dividend shifts out of the top of the quotient register while
    // quotient bits shift in at the bottom.
    assign trial = {r_rem, r_quo[tcr_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, r_divisor};
    assign fits  = (trial >= {1'b0, r_divisor});
    assign n_rem = fits ? diff[15:0] : trial[15:0];

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= tcr_pkg::DIV_CNT_W'(tcr_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - tcr_pkg::DIV_CNT_W'(1);
                if (r_cnt == tcr_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_divisor <= i_divisor;
            r_quo     <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[tcr_pkg::DIV_W-2:0], fits};
        end
    end

endmodule

// ===== src/tcr_back.sv =====
// Back end: executes queued commands, holds the column state and the texture
// store, and streams pixel writes. Depends on tcr_pkg and tcr_div.
module tcr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tcr_pkg::t_cfg   i_cfg,
    input  logic            i_head_valid,
    input  tcr_pkg::t_cmd   i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [23:0]     o_screen_address,
    output logic [31:0]     o_pixel_color,
    output logic [1:0]      o_region,
    output logic            o_last_of_column
);

    tcr_pkg::t_back_state r_state;
    tcr_pkg::t_back_state n_state;

    // Column state.
    logic                          r_busy;
    logic [12:0]                   r_row;
    logic [12:0]                   r_end;
    logic [11:0]                   r_first;
    logic [12:0]                   r_bound;
    logic [11:0]                   r_col;
    logic [6:0]                    r_tcol;
    logic [tcr_pkg::POS_W-1:0]     r_pos;
    logic [tcr_pkg::STEP_W-1:0]    r_step;
    logic signed [17:0]            r_base;
    logic                          r_wr_zero;

    // Texture store and read stage.
    logic [31:0]                   r_texture [tcr_pkg::TEXTURE_DEPTH];
    logic [31:0]                   r_rd_data;
    logic                          r_b_valid;
    tcr_pkg::t_region              r_b_region;
    logic [23:0]                   r_b_addr;
    logic [31:0]                   r_b_color;
    logic                          r_b_last;

    // Output register.
    logic                          r_out_valid;
    tcr_pkg::t_region              r_out_region;
    logic [23:0]                   r_out_addr;
    logic [31:0]                   r_out_color;
    logic                          r_out_last;

    // Control from the sequencer.
    logic pop;
    logic mem_we;
    logic start_take;
    logic div_start;
    logic issue;

    logic out_free;
    logic b_free;

    // Pixel issue path.
    logic                          a_ceiling;
    logic                          a_wall;
    tcr_pkg::t_region              a_region;
    logic [tcr_pkg::TEX_AW-1:0]    a_int_low;
    logic [tcr_pkg::TEX_AW-1:0]    a_mask;
    logic [tcr_pkg::TEX_AW-1:0]    a_ty;
    logic [tcr_pkg::TEX_IDX_W-1:0] a_idx_sum;
    logic [tcr_pkg::TEX_AW-1:0]    a_idx;
    logic [25:0]                   a_addr_sum;
    logic [31:0]                   a_color;
    logic [13:0]                   a_row_next;
    logic                          a_last;

    // Column start path.
    logic [22:0]                   s_tcol_prod;
    logic [12:0]                   s_end;
    logic [12:0]                   s_bound_m1;
    logic [12:0]                   s_height_m1;
    logic signed [17:0]            s_base;

    logic                          div_done;
    logic [tcr_pkg::DIV_W-1:0]     div_quotient;
    logic signed [50:0]            mul_prod;

    assign out_free = !r_out_valid || !i_out_stall;
    assign b_free   = !r_b_valid || out_free;

    // Region of the current row.
    assign a_ceiling = (r_row < {1'b0, r_first});
    assign a_wall    = !a_ceiling && (r_row < tcr_pkg::floor_minus_one(r_bound));
    assign a_region  = a_ceiling ? tcr_pkg::RG_CEILING :
                       (a_wall ? tcr_pkg::RG_WALL : tcr_pkg::RG_FLOOR);

    // Integer part truncated toward zero: a negative position with a nonzero
    // fraction rounds up by one. Only the bits that reach the address matter.
    assign a_int_low = r_pos[tcr_pkg::FRAC_BITS +: tcr_pkg::TEX_AW]
                     + tcr_pkg::TEX_AW'(r_pos[tcr_pkg::POS_W-1]
                                        && (r_pos[tcr_pkg::FRAC_BITS-1:0] != '0));
    // A zero texture height wraps its mask to all ones.
    assign a_mask    = (i_cfg.texture_height == 7'd0) ? '1 :
                       tcr_pkg::TEX_AW'(i_cfg.texture_height - 7'd1);
    assign a_ty      = a_int_low & a_mask;
    assign a_idx_sum = tcr_pkg::TEX_IDX_W'(a_ty) * tcr_pkg::TEX_IDX_W'(i_cfg.texture_width)
                     + tcr_pkg::TEX_IDX_W'(r_tcol);
    assign a_idx     = a_idx_sum[tcr_pkg::TEX_AW-1:0];

    assign a_addr_sum = 26'(r_row) * 26'(i_cfg.screen_width) + 26'(r_col);
    assign a_color    = a_ceiling ? {8'd0, i_cfg.ceiling_color} : {8'd0, i_cfg.floor_color};
    assign a_row_next = {1'b0, r_row} + 14'd1;
    assign a_last     = (a_row_next >= {1'b0, r_end});

    // Column setup values.
    assign s_tcol_prod = 23'(i_head.hit_fraction) * 23'(i_cfg.texture_width);
    assign s_bound_m1  = tcr_pkg::floor_minus_one(i_head.span_end);
    assign s_height_m1 = tcr_pkg::floor_minus_one(i_cfg.screen_height);
    assign s_base      = $signed(18'(i_head.span_start))
                       - $signed(18'(i_cfg.screen_height[12:1]))
                       + $signed(18'(i_head.wall_rows[15:1]));

    always_comb begin
        s_end = {1'b0, i_head.span_start};
        if (s_bound_m1 > s_end) begin
            s_end = s_bound_m1;
        end
        if (s_height_m1 > s_end) begin
            s_end = s_height_m1;
        end
    end

    assign mul_prod = r_base * $signed({1'b0, r_step});

    tcr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({i_cfg.texture_height, {tcr_pkg::FRAC_BITS{1'b0}}}),
        .i_divisor  (i_head.wall_rows),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    always_comb begin
        n_state    = r_state;
        pop        = 1'b0;
        mem_we     = 1'b0;
        start_take = 1'b0;
        div_start  = 1'b0;
        issue      = 1'b0;
        case (r_state)
            tcr_pkg::BK_RUN: begin
                if (i_head_valid) begin
                    case (i_head.kind)
                        tcr_pkg::CMD_LOAD: begin
                            pop    = 1'b1;
                            mem_we = 1'b1;
                        end
                        tcr_pkg::CMD_START: begin
                            pop        = 1'b1;
                            start_take = 1'b1;
                            div_start  = 1'b1;
                            n_state    = tcr_pkg::BK_DIV;
                        end
                        tcr_pkg::CMD_PIXEL: begin
                            // Without an active column the item is dropped.
                            if (!r_busy) begin
                                pop = 1'b1;
                            end else if (b_free) begin
                                pop   = 1'b1;
                                issue = 1'b1;
                            end
                        end
                        default: pop = 1'b1;
                    endcase
                end
            end
            tcr_pkg::BK_DIV: begin
                if (div_done) begin
                    n_state = tcr_pkg::BK_MUL;
                end
            end
            tcr_pkg::BK_MUL: n_state = tcr_pkg::BK_RUN;
            default:         n_state = tcr_pkg::BK_RUN;
        endcase
    end

    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcr_pkg::BK_RUN;
            r_busy      <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (start_take) begin
                r_busy <= 1'b0;
            end else if (r_state == tcr_pkg::BK_MUL) begin
                r_busy <= (r_end != 13'd0);
            end else if (issue && a_last) begin
                r_busy <= 1'b0;
            end
            if (b_free) begin
                r_b_valid <= issue;
            end
            if (out_free) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_take) begin
            r_col     <= i_head.column_x;
            r_first   <= i_head.span_start;
            r_bound   <= i_head.span_end;
            r_tcol    <= s_tcol_prod[22:16];
            r_end     <= s_end;
            r_row     <= '0;
            r_base    <= s_base;
            r_wr_zero <= (i_head.wall_rows == 16'd0);
        end
        if (r_state == tcr_pkg::BK_DIV && div_done) begin
            r_step <= r_wr_zero ? tcr_pkg::STEP_SAT : tcr_pkg::STEP_W'(div_quotient);
        end
        if (r_state == tcr_pkg::BK_MUL) begin
            r_pos <= mul_prod[tcr_pkg::POS_W-1:0];
        end
        if (issue) begin
            r_row      <= a_row_next[12:0];
            r_b_region <= a_region;
            r_b_addr   <= a_addr_sum[23:0];
            r_b_color  <= a_color;
            r_b_last   <= a_last;
            if (a_wall) begin
                r_pos <= r_pos + tcr_pkg::POS_W'(r_step);
            end
        end
        if (out_free && r_b_valid) begin
            r_out_region <= r_b_region;
            r_out_addr   <= r_b_addr;
            r_out_color  <= (r_b_region == tcr_pkg::RG_WALL) ? r_rd_data : r_b_color;
            r_out_last   <= r_b_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_texture[i_head.texel_index] <= i_head.texel_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_texture[a_idx];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_screen_address = r_out_addr;
    assign o_pixel_color    = r_out_color;
    assign o_region         = r_out_region;
    assign o_last_of_column = r_out_last;

endmodule

// ===== src/textured_column_renderer.sv =====
// Top level of the textured column renderer: configuration registers,
// front end with command queue, and back end. Depends on tcr_pkg,
// tcr_front and tcr_back.
//
// Usage: items enter on the input channel (i_in_valid / o_in_stall) and are
// taken at an edge where valid is high and stall is low. Pixel writes leave on
// the output channel (o_out_valid / i_out_stall) with the same rule.
// A load-texel item writes one texture word and gives no transfer. A
// start-column item gives no transfer and occupies the back end while the
// bit-serial step divider and the position multiply that follows it run.
// Next-pixel items then stream one per cycle through the texture read stage
// while the output is not stalled; each passes the read stage register and
// the output register before its pixel transfer is offered.
// A four-entry queue separates the two ends, so the input keeps accepting
// while the receiver stalls until the queue fills; a stalled output holds
// its payload. Reset empties the queue, drops any active column and
// restores the default configuration; the texture store is not cleared.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user must do so only while no work is pending; the block does not enforce it.
module textured_column_renderer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_opcode,
    input  logic [11:0]                    i_column_x,
    input  logic [11:0]                    i_span_start,
    input  logic [12:0]                    i_span_end,
    input  logic [15:0]                    i_wall_rows,
    input  logic [15:0]                    i_hit_fraction,
    input  logic [11:0]                    i_texel_index,
    input  logic [31:0]                    i_texel_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [23:0]                    o_screen_address,
    output logic [31:0]                    o_pixel_color,
    output logic [1:0]                     o_region,
    output logic                           o_last_of_column,
    input  logic                           i_cfg_we,
    input  logic [tcr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tcr_pkg::t_cfg r_cfg;
    tcr_pkg::t_cmd head;
    logic          head_valid;
    logic          pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width   <= 13'd640;
            r_cfg.screen_height  <= 13'd480;
            r_cfg.ceiling_color  <= 24'd0;
            r_cfg.floor_color    <= 24'd0;
            r_cfg.texture_width  <= 7'd64;
            r_cfg.texture_height <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tcr_pkg::CFG_SCREEN_WIDTH:   r_cfg.screen_width   <= i_cfg_data[12:0];
                tcr_pkg::CFG_SCREEN_HEIGHT:  r_cfg.screen_height  <= i_cfg_data[12:0];
                tcr_pkg::CFG_CEILING_COLOR:  r_cfg.ceiling_color  <= i_cfg_data[23:0];
                tcr_pkg::CFG_FLOOR_COLOR:    r_cfg.floor_color    <= i_cfg_data[23:0];
                tcr_pkg::CFG_TEXTURE_WIDTH:  r_cfg.texture_width  <= i_cfg_data[6:0];
                tcr_pkg::CFG_TEXTURE_HEIGHT: r_cfg.texture_height <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    tcr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_column_x     (i_column_x),
        .i_span_start   (i_span_start),
        .i_span_end     (i_span_end),
        .i_wall_rows    (i_wall_rows),
        .i_hit_fraction (i_hit_fraction),
        .i_texel_index  (i_texel_index),
        .i_texel_value  (i_texel_value),
        .i_pop          (pop),
        .o_head_valid   (head_valid),
        .o_head         (head)
    );

    tcr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_head_valid     (head_valid),
        .i_head           (head),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_screen_address (o_screen_address),
        .o_pixel_color    (o_pixel_color),
        .o_region         (o_region),
        .o_last_of_column (o_last_of_column)
    );

endmodule

// ===== src/tcr_checker.sv =====
// Port-level checks for the textured column renderer, bound to the top level.
// Depends on tcr_pkg for region codes.
module tcr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [23:0] o_screen_address,
    input logic [31:0] o_pixel_color,
    input logic [1:0]  o_region,
    input logic        o_last_of_column
);

    // A stalled pixel transfer keeps its whole payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable(o_screen_address) && $stable(o_pixel_color)
            && $stable(o_region) && $stable(o_last_of_column))
        else $error("stalled output transfer changed");

    // Ceiling and floor colors are 24-bit, so their top byte is always clear.
    a_flat_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_region == tcr_pkg::RG_CEILING || o_region == tcr_pkg::RG_FLOOR)
            |-> o_pixel_color[31:24] == 8'd0)
        else $error("flat color with nonzero top byte");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Reset empties the command queue, so input is open right after it.
    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind textured_column_renderer tcr_checker u_checker (.*);
